// ----- sv/piecewise_range_compensation_top_macros.svh -----
// Assertion helpers shared by the block's RTL.
`ifndef PIECEWISE_RANGE_COMPENSATION_TOP_MACROS_SVH
`define PIECEWISE_RANGE_COMPENSATION_TOP_MACROS_SVH

// Same-cycle implication, reset-gated.
`define PRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, reset-gated.
`define PRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/prc_pkg.sv -----
`timescale 1ns / 1ps

package prc_pkg;

  // Segment codes as reported on segment_used_o
  typedef enum logic [1:0] {
    SEG_NEAR = 2'd0,
    SEG_MID  = 2'd1,
    SEG_FAR  = 2'd2,
    SEG_BYP  = 2'd3
  } seg_e;

  // Register indexes
  localparam logic [7:0] REG_NEAR_LIMIT  = 8'd0;
  localparam logic [7:0] REG_MID_LIMIT   = 8'd1;
  localparam logic [7:0] REG_NEAR_GAIN   = 8'd2;
  localparam logic [7:0] REG_NEAR_OFFSET = 8'd3;
  localparam logic [7:0] REG_MID_GAIN    = 8'd4;
  localparam logic [7:0] REG_MID_OFFSET  = 8'd5;
  localparam logic [7:0] REG_FAR_GAIN    = 8'd6;
  localparam logic [7:0] REG_FAR_OFFSET  = 8'd7;

  // Stage counts of the root and divide pipes
  localparam int NSQ  = 32;
  localparam int NDIV = 33;

  typedef logic [2:0][31:0] vec3_t;

endpackage

// ----- sv/piecewise_range_compensation_top.sv -----
`timescale 1ns / 1ps
// Piecewise range compensation of a Q16.16 translation vector.
// Input channel: in_valid_i/in_ready_o with pos_x_i, pos_y_i, pos_z_i.
// Output channel: out_valid_o/out_ready_i with out_x_o, out_y_o, out_z_o,
// segment_used_o and saturated_o; one result per input transfer, in order.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// always ready, indexes above 7 are dropped. Write only while idle.
// From input transfer to result valid, 2 stages form
// the squared distance, 32 stages take the square root one bit each,
// 5 stages pick the segment and build the scaled numerator, 33 stages
// divide one quotient bit each, and one output register.
// Throughput is one vector per cycle while results are taken. The whole
// pipe advances together; when the output register holds a result the
// receiver does not take, in_ready_o drops and every stage holds, so
// nothing is lost or repeated. Reset empties the pipe and loads the
// default limits (3 m, 5 m), unity gains and zero offsets.
module piecewise_range_compensation_top
  import prc_pkg::*;
#(
  parameter int COMPENSATE = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [1:0]  segment_used_o,
  output logic        saturated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Config registers
  logic [31:0] near_limit_q, mid_limit_q;
  logic [31:0] near_gain_q, near_offset_q, mid_gain_q, mid_offset_q;
  logic [31:0] far_gain_q, far_offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_limit_q  <= 32'd196608;
      mid_limit_q   <= 32'd327680;
      near_gain_q   <= 32'd65536;
      near_offset_q <= 32'd0;
      mid_gain_q    <= 32'd65536;
      mid_offset_q  <= 32'd0;
      far_gain_q    <= 32'd65536;
      far_offset_q  <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NEAR_LIMIT:  near_limit_q  <= cfg_data_i;
        REG_MID_LIMIT:   mid_limit_q   <= cfg_data_i;
        REG_NEAR_GAIN:   near_gain_q   <= cfg_data_i;
        REG_NEAR_OFFSET: near_offset_q <= cfg_data_i;
        REG_MID_GAIN:    mid_gain_q    <= cfg_data_i;
        REG_MID_OFFSET:  mid_offset_q  <= cfg_data_i;
        REG_FAR_GAIN:    far_gain_q    <= cfg_data_i;
        REG_FAR_OFFSET:  far_offset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: move when the output register is free or being taken
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  vec3_t pos_in;
  assign pos_in = {pos_z_i, pos_y_i, pos_x_i};

  // Stage A: squares of magnitudes
  logic               a_vld_q;
  vec3_t              a_pos_q;
  logic [2:0][63:0]   a_sq_q;
  logic [2:0][31:0]   a_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag[i] = pos_in[i][31] ? (32'd0 - pos_in[i]) : pos_in[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pos_q <= pos_in;
      for (int i = 0; i < 3; i++) a_sq_q[i] <= a_mag[i] * a_mag[i];
    end
  end

  // Stage B: sum of squares
  logic        b_vld_q;
  vec3_t       b_pos_q;
  logic [63:0] b_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_pos_q <= a_pos_q;
      b_s_q   <= a_sq_q[0] + a_sq_q[1] + a_sq_q[2];
    end
  end

  // Square root: one result bit per stage
  logic        sq_vld_q  [NSQ];
  vec3_t       sq_pos_q  [NSQ];
  logic [63:0] sq_s_q    [NSQ];
  logic [33:0] sq_rem_q  [NSQ];
  logic [31:0] sq_root_q [NSQ];

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic        vld_in;
    vec3_t       pos_in_k;
    logic [63:0] s_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] t;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign vld_in   = b_vld_q;
      assign pos_in_k = b_pos_q;
      assign s_in     = b_s_q;
      assign rem_in   = 34'd0;
      assign root_in  = 32'd0;
    end else begin : g_next
      assign vld_in   = sq_vld_q[k-1];
      assign pos_in_k = sq_pos_q[k-1];
      assign s_in     = sq_s_q[k-1];
      assign rem_in   = sq_rem_q[k-1];
      assign root_in  = sq_root_q[k-1];
    end

    assign t     = {rem_in, s_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_vld_q[k] <= 1'b0;
      else if (en) sq_vld_q[k] <= vld_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_pos_q[k]  <= pos_in_k;
        sq_s_q[k]    <= {s_in[61:0], 2'b00};
        sq_rem_q[k]  <= ge ? 34'(t - trial) : t[33:0];
        sq_root_q[k] <= {root_in[30:0], ge};
      end
    end
  end

  // Stage E: segment select
  logic [31:0] root_d;
  assign root_d = sq_root_q[NSQ-1];

  logic        e_vld_q;
  vec3_t       e_pos_q;
  logic [31:0] e_d_q;
  seg_e        e_seg_q;
  logic [31:0] e_gain_q, e_off_q;
  logic        e_byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else if (en) e_vld_q <= sq_vld_q[NSQ-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_pos_q <= sq_pos_q[NSQ-1];
      e_d_q   <= root_d;
      e_byp_q <= (root_d == 32'd0) || (COMPENSATE == 0);
      if (root_d <= near_limit_q) begin
        e_seg_q  <= SEG_NEAR;
        e_gain_q <= near_gain_q;
        e_off_q  <= near_offset_q;
      end else if (root_d <= mid_limit_q) begin
        e_seg_q  <= SEG_MID;
        e_gain_q <= mid_gain_q;
        e_off_q  <= mid_offset_q;
      end else begin
        e_seg_q  <= SEG_FAR;
        e_gain_q <= far_gain_q;
        e_off_q  <= far_offset_q;
      end
    end
  end

  // Stage F: gain times distance
  logic               f_vld_q;
  vec3_t              f_pos_q;
  logic [31:0]        f_d_q;
  seg_e               f_seg_q;
  logic [31:0]        f_off_q;
  logic               f_byp_q;
  logic signed [64:0] f_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_vld_q <= 1'b0;
    else if (en) f_vld_q <= e_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_pos_q  <= e_pos_q;
      f_d_q    <= e_d_q;
      f_seg_q  <= e_seg_q;
      f_off_q  <= e_off_q;
      f_byp_q  <= e_byp_q;
      f_prod_q <= 65'($signed(e_gain_q) * $signed({1'b0, e_d_q}));
    end
  end

  // Stage G: corrected distance, kept as sign and magnitude
  logic signed [64:0] g_rnd;
  logic signed [48:0] g_c;

  always_comb begin
    g_rnd = (f_prod_q + (f_prod_q[64] ? 65'sd65535 : 65'sd0)) >>> 16;
    g_c   = 49'(g_rnd) + 49'($signed(f_off_q));
  end

  logic        g_vld_q;
  vec3_t       g_pos_q;
  logic [31:0] g_d_q;
  seg_e        g_seg_q;
  logic        g_byp_q;
  logic        g_csign_q;
  logic [47:0] g_cmag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_vld_q <= 1'b0;
    else if (en) g_vld_q <= f_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_pos_q   <= f_pos_q;
      g_d_q     <= f_d_q;
      g_seg_q   <= f_seg_q;
      g_byp_q   <= f_byp_q;
      g_csign_q <= g_c[48];
      g_cmag_q  <= g_c[48] ? 48'(-g_c) : g_c[47:0];
    end
  end

  // Stage H: partial products of |comp| * |C|
  logic [2:0][31:0] h_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_mag[i] = g_pos_q[i][31] ? (32'd0 - g_pos_q[i]) : g_pos_q[i];
    end
  end

  logic             h_vld_q;
  vec3_t            h_pos_q;
  logic [31:0]      h_d_q;
  seg_e             h_seg_q;
  logic             h_byp_q;
  logic [2:0]       h_neg_q;
  logic [2:0][63:0] h_pl_q;
  logic [2:0][47:0] h_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_vld_q <= 1'b0;
    else if (en) h_vld_q <= g_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_pos_q <= g_pos_q;
      h_d_q   <= g_d_q;
      h_seg_q <= g_seg_q;
      h_byp_q <= g_byp_q;
      for (int i = 0; i < 3; i++) begin
        h_neg_q[i] <= g_pos_q[i][31] ^ g_csign_q;
        h_pl_q[i]  <= h_mag[i] * g_cmag_q[31:0];
        h_ph_q[i]  <= 48'(h_mag[i] * g_cmag_q[47:32]);
      end
    end
  end

  // Stage I: full numerator, overflow check of the high part
  logic [2:0][79:0] i_num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      i_num[i] = {16'd0, h_pl_q[i]} + {h_ph_q[i], 32'd0};
    end
  end

  logic             i_vld_q;
  vec3_t            i_pos_q;
  logic [31:0]      i_d_q;
  seg_e             i_seg_q;
  logic             i_byp_q;
  logic [2:0]       i_neg_q;
  logic [2:0]       i_ovf_q;
  logic [2:0][31:0] i_rem_q;
  logic [2:0][32:0] i_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) i_vld_q <= 1'b0;
    else if (en) i_vld_q <= h_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_pos_q <= h_pos_q;
      i_d_q   <= h_d_q;
      i_seg_q <= h_seg_q;
      i_byp_q <= h_byp_q;
      i_neg_q <= h_neg_q;
      for (int i = 0; i < 3; i++) begin
        i_ovf_q[i] <= i_num[i][79:33] >= {15'd0, h_d_q};
        i_rem_q[i] <= i_num[i][64:33];
        i_low_q[i] <= i_num[i][32:0];
      end
    end
  end

  // Divide: one quotient bit per stage, three lanes
  logic             dv_vld_q [NDIV];
  vec3_t            dv_pos_q [NDIV];
  logic [31:0]      dv_d_q   [NDIV];
  seg_e             dv_seg_q [NDIV];
  logic             dv_byp_q [NDIV];
  logic [2:0]       dv_neg_q [NDIV];
  logic [2:0]       dv_ovf_q [NDIV];
  logic [2:0][31:0] dv_rem_q [NDIV];
  logic [2:0][32:0] dv_low_q [NDIV];
  logic [2:0][32:0] dv_quo_q [NDIV];

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic             vld_in;
    vec3_t            pos_in_k;
    logic [31:0]      d_in;
    seg_e             seg_in;
    logic             byp_in;
    logic [2:0]       neg_in, ovf_in;
    logic [2:0][31:0] rem_in;
    logic [2:0][32:0] low_in, quo_in;
    logic [2:0][32:0] t;
    logic [2:0]       ge;

    if (k == 0) begin : g_first
      assign vld_in   = i_vld_q;
      assign pos_in_k = i_pos_q;
      assign d_in     = i_d_q;
      assign seg_in   = i_seg_q;
      assign byp_in   = i_byp_q;
      assign neg_in   = i_neg_q;
      assign ovf_in   = i_ovf_q;
      assign rem_in   = i_rem_q;
      assign low_in   = i_low_q;
      assign quo_in   = '0;
    end else begin : g_next
      assign vld_in   = dv_vld_q[k-1];
      assign pos_in_k = dv_pos_q[k-1];
      assign d_in     = dv_d_q[k-1];
      assign seg_in   = dv_seg_q[k-1];
      assign byp_in   = dv_byp_q[k-1];
      assign neg_in   = dv_neg_q[k-1];
      assign ovf_in   = dv_ovf_q[k-1];
      assign rem_in   = dv_rem_q[k-1];
      assign low_in   = dv_low_q[k-1];
      assign quo_in   = dv_quo_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {rem_in[i], low_in[i][32]};
        ge[i] = t[i] >= {1'b0, d_in};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[k] <= 1'b0;
      else if (en) dv_vld_q[k] <= vld_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_pos_q[k] <= pos_in_k;
        dv_d_q[k]   <= d_in;
        dv_seg_q[k] <= seg_in;
        dv_byp_q[k] <= byp_in;
        dv_neg_q[k] <= neg_in;
        dv_ovf_q[k] <= ovf_in;
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[k][i] <= ge[i] ? 32'(t[i] - {1'b0, d_in}) : t[i][31:0];
          dv_low_q[k][i] <= {low_in[i][31:0], 1'b0};
          dv_quo_q[k][i] <= {quo_in[i][31:0], ge[i]};
        end
      end
    end
  end

  // Output stage: sign, saturation, bypass
  localparam int L = NDIV - 1;

  vec3_t      res;
  logic [2:0] sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_neg_q[L][i]) begin
        sat[i] = dv_ovf_q[L][i] || (dv_quo_q[L][i] > 33'h080000000);
        res[i] = sat[i] ? 32'h80000000 : (32'd0 - dv_quo_q[L][i][31:0]);
      end else begin
        sat[i] = dv_ovf_q[L][i] || (dv_quo_q[L][i] > 33'h07fffffff);
        res[i] = sat[i] ? 32'h7fffffff : dv_quo_q[L][i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= dv_vld_q[L];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_byp_q[L]) begin
        out_x_o        <= dv_pos_q[L][0];
        out_y_o        <= dv_pos_q[L][1];
        out_z_o        <= dv_pos_q[L][2];
        segment_used_o <= SEG_BYP;
        saturated_o    <= 1'b0;
      end else begin
        out_x_o        <= res[0];
        out_y_o        <= res[1];
        out_z_o        <= res[2];
        segment_used_o <= dv_seg_q[L];
        saturated_o    <= |sat;
      end
    end
  end

`include "piecewise_range_compensation_top_macros.svh"

  // Bypassed results never report clipping
  `PRC_ASSERT_IMP(a_byp_no_sat, out_valid_o && (segment_used_o == SEG_BYP), !saturated_o)
  // Near segment only within the near limit
  `PRC_ASSERT_IMP(a_near_seg, e_vld_q && (e_seg_q == SEG_NEAR), e_d_q <= near_limit_q)
  // A stalled pipe holds its distance stage
  `PRC_ASSERT_NXT(a_stall_hold, !en, $stable(e_d_q) && $stable(e_vld_q))

endmodule

// ----- tb/sv/tb_piecewise_range_compensation_top.sv -----
`timescale 1ns / 1ps

module tb_piecewise_range_compensation_top;
  import prc_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int IDLE_LIMIT = 3000;
  localparam int PHASE_ITEMS = 180;
  localparam int NUM_PHASES = 8;
  localparam logic [7:0] REG_UNUSED_LO = 8'd8;

  // One compensated vector as seen on the output channel
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    seg_e        seg;
    logic        sat;
  } comp_vec_t;

  // Predicts compensated vectors and checks them in order
  class range_scoreboard;
    logic [31:0] regs [8];
    comp_vec_t   expected_q [$];
    int          errors;
    int          checked;
    int          seg_hits [4];
    int          sat_hits;

    function new();
      errors = 0;
      checked = 0;
      sat_hits = 0;
      foreach (seg_hits[i]) seg_hits[i] = 0;
      reset_regs();
    endfunction

    function void reset_regs();
      regs[REG_NEAR_LIMIT]  = 32'd196608;
      regs[REG_MID_LIMIT]   = 32'd327680;
      regs[REG_NEAR_GAIN]   = 32'd65536;
      regs[REG_NEAR_OFFSET] = 32'd0;
      regs[REG_MID_GAIN]    = 32'd65536;
      regs[REG_MID_OFFSET]  = 32'd0;
      regs[REG_FAR_GAIN]    = 32'd65536;
      regs[REG_FAR_OFFSET]  = 32'd0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      if (idx < REG_UNUSED_LO) regs[idx] = data;
    endfunction

    // floor(sqrt(n)), one result bit per pass
    function automatic logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // comp * corr / rng, toward zero, clipped to 32 bits
    function automatic logic [31:0] rescale(longint comp, longint corr,
                                            logic [63:0] rng, output logic clip);
      logic [63:0] a;
      logic [63:0] cm;
      logic [63:0] m;
      a  = magnitude(comp);
      cm = magnitude(corr);
      m  = a * (cm / rng) + (a * (cm % rng)) / rng;
      clip = 1'b0;
      if ((comp < 0) != (corr < 0)) begin
        if (m > 64'd2147483648) begin
          clip = 1'b1;
          return 32'h8000_0000;
        end
        return 32'(-m);
      end
      if (m > 64'd2147483647) begin
        clip = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return m[31:0];
    endfunction

    function void note_vector(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      comp_vec_t   e;
      longint      v [3];
      logic [31:0] r [3];
      logic [63:0] sq;
      logic [63:0] rng;
      longint      gain;
      longint      offs;
      longint      corr;
      logic        clip;
      v[0] = longint'(signed'(px));
      v[1] = longint'(signed'(py));
      v[2] = longint'(signed'(pz));
      r[0] = px;
      r[1] = py;
      r[2] = pz;
      e.seg = SEG_BYP;
      e.sat = 1'b0;
      sq = '0;
      for (int i = 0; i < 3; i++) sq += magnitude(v[i]) * magnitude(v[i]);
      rng = root_floor(sq);
      if (rng != 0) begin
        if (rng <= 64'(regs[REG_NEAR_LIMIT])) begin
          e.seg = SEG_NEAR;
          gain = longint'(signed'(regs[REG_NEAR_GAIN]));
          offs = longint'(signed'(regs[REG_NEAR_OFFSET]));
        end else if (rng <= 64'(regs[REG_MID_LIMIT])) begin
          e.seg = SEG_MID;
          gain = longint'(signed'(regs[REG_MID_GAIN]));
          offs = longint'(signed'(regs[REG_MID_OFFSET]));
        end else begin
          e.seg = SEG_FAR;
          gain = longint'(signed'(regs[REG_FAR_GAIN]));
          offs = longint'(signed'(regs[REG_FAR_OFFSET]));
        end
        // signed division truncates toward zero
        corr = (gain * longint'(rng)) / 65536 + offs;
        for (int i = 0; i < 3; i++) begin
          r[i] = rescale(v[i], corr, rng, clip);
          e.sat |= clip;
        end
      end
      e.x = r[0];
      e.y = r[1];
      e.z = r[2];
      seg_hits[e.seg]++;
      if (e.sat) sat_hits++;
      expected_q.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, checked);
      errors++;
    endtask

    task check_result(comp_vec_t got);
      comp_vec_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", got.x, 32'd0);
        return;
      end
      e = expected_q.pop_front();
      if (got.x !== e.x) report("out_x", got.x, e.x);
      if (got.y !== e.y) report("out_y", got.y, e.y);
      if (got.z !== e.z) report("out_z", got.z, e.z);
      if (got.seg !== e.seg) report("segment_used", 32'(got.seg), 32'(e.seg));
      if (got.sat !== e.sat) report("saturated", 32'(got.sat), 32'(e.sat));
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [1:0]  seg_used;
  logic        sat_flag;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  range_scoreboard sb;
  bit calm;
  bit stim_done;
  int sent;
  int idle_cycles;

  piecewise_range_compensation_top #(.COMPENSATE(1)) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_z_o        (out_z),
    .segment_used_o (seg_used),
    .saturated_o    (sat_flag),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // Push one vector; valid stays high across back-to-back transfers
  task send_vector(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    sb.note_vector(px, py, pz);
    sent++;
    @(posedge clk);
  endtask

  // Valid stays high across back-to-back writes; the caller drops it
  task write_cfg(logic [7:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] small_comp();
    return 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
  endfunction

  // Mix of full-range, short-range and single-axis vectors
  task send_random();
    logic [31:0] c [3];
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0, 1: begin
          c[i] = $urandom();
        end
        2: begin
          c[i] = (i == 0) ? $urandom() : small_comp();
        end
        3: begin
          c[i] = ($urandom_range(0, 2) == 0) ? 32'd0 : small_comp();
        end
        default: begin
          c[i] = small_comp();
        end
      endcase
    end
    send_vector(c[0], c[1], c[2]);
  endtask

  task load_phase(int p);
    logic [31:0] v [8];
    case (p)
      1: begin
        v = '{32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      end
      2: begin
        v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      end
      3: begin
        // mid limit below near limit
        v = '{32'h0005_0000, 32'h0002_0000, 32'h0001_8000, 32'h0000_4000,
              32'h0000_8000, 32'hFFFF_C000, 32'h0000_F000, 32'h0001_0000};
      end
      default: begin
        v[REG_NEAR_LIMIT] = $urandom_range(0, 32'h0006_0000);
        v[REG_MID_LIMIT] = v[REG_NEAR_LIMIT] + $urandom_range(0, 32'h0006_0000);
        for (int i = 2; i < 8; i++) begin
          v[i] = ($urandom_range(0, 3) == 0) ? $urandom()
               : 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0001_0000);
        end
      end
    endcase
    for (int i = 0; i < 8; i++) write_cfg(8'(i), v[i]);
    write_cfg(8'($urandom_range(8, 255)), $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, checks each transfer
  initial begin
    comp_vec_t got;
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      got.x = out_x;
      got.y = out_y;
      got.z = out_z;
      got.seg = seg_e'(seg_used);
      got.sat = sat_flag;
      sb.check_result(got);
      @(posedge clk);
    end
  end

  // Watchdog on cycles with no transfer on any channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
          || stim_done)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb_piecewise_range_compensation_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int limit;
    sb = new();
    calm = 1'b0;
    stim_done = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector, extremes, segment boundaries at reset limits
    send_vector(32'd0, 32'd0, 32'd0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_vector(32'd1, 32'd0, 32'd0);
    send_vector(32'd0, 32'hFFFF_FFFF, 32'd0);
    send_vector(32'd0, 32'd0, 32'h0003_0000);
    send_vector(32'd0, 32'd0, 32'h0003_0001);
    send_vector(32'hFFFB_0000, 32'd0, 32'd0);
    send_vector(32'hFFFA_FFFF, 32'd0, 32'd0);
    send_vector(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    drain();
    // Same boundaries with a non-unity gain or nonzero offset in every segment
    write_cfg(REG_NEAR_GAIN, 32'h0001_1000);
    write_cfg(REG_MID_OFFSET, 32'hFFFF_8000);
    write_cfg(REG_FAR_GAIN, 32'h0000_E000);
    write_cfg(REG_FAR_OFFSET, 32'h0000_2000);
    cfg_valid <= 1'b0;
    send_vector(32'd0, 32'd0, 32'h0003_0000);
    send_vector(32'd0, 32'd0, 32'h0003_0001);
    send_vector(32'd0, 32'h0005_0001, 32'd0);
    send_vector(32'h8000_0000, 32'd0, 32'd0);
    send_vector(32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0001);
    send_vector(32'd0, 32'd0, 32'd0);
    drain();

    for (int p = 1; p <= NUM_PHASES; p++) begin
      load_phase(p);
      calm = (p % 3 == 0);
      limit = (p == 1 || p == 2) ? PHASE_ITEMS / 2 : PHASE_ITEMS + PHASE_ITEMS / 6;
      for (int n = 0; n < limit; n++) send_random();
      drain();
      calm = 1'b0;
    end

    stim_done = 1'b1;
    in_valid <= 1'b0;
    repeat (100) @(posedge clk);
    $display("sent %0d vectors, checked %0d results over %0d register settings",
             sent, sb.checked, NUM_PHASES + 2);
    $display("segments near/mid/far/bypass %0d/%0d/%0d/%0d, clipped %0d",
             sb.seg_hits[0], sb.seg_hits[1], sb.seg_hits[2], sb.seg_hits[3], sb.sat_hits);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_piecewise_range_compensation_top: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("tb_piecewise_range_compensation_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- piecewise_range_compensation_top.f -----
+incdir+sv
sv/prc_pkg.sv
sv/piecewise_range_compensation_top.sv
tb/sv/tb_piecewise_range_compensation_top.sv
